### rtl/hdd_pkg.sv
// ----------------------------------------------------------------------------
// hdd_pkg
// Shared widths, grid geometry and codes for the height grid delta decoder.
// ----------------------------------------------------------------------------
package hdd_pkg;

  // grid geometry
  localparam int GRID_PITCH = 33;
  localparam int HALF_PITCH = GRID_PITCH / 2;
  localparam int QUAD_PITCH = HALF_PITCH + 1;
  localparam int CNT_W      = $clog2(GRID_PITCH);

  // field widths
  localparam int BASE_W   = 28;
  localparam int DELTA_W  = 8;
  localparam int ACC_W    = 29;
  localparam int HEIGHT_W = 32;
  localparam int INDEX_W  = 9;
  localparam int QUAD_W   = 2;
  localparam int NUM_QUADS = 4;
  localparam int FRAC_W   = 4;
  localparam int SCALE_W  = 3;
  localparam int PROD_W   = 2 * CNT_W + INDEX_W;

  localparam logic signed [HEIGHT_W-1:0] HEIGHT_MOST_POS = {1'b0, {(HEIGHT_W-1){1'b1}}};
  localparam logic signed [HEIGHT_W-1:0] HEIGHT_MOST_NEG = {1'b1, {(HEIGHT_W-1){1'b0}}};

  // result kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_MINMAX = 1'b1;

endpackage

### rtl/hdd_in_if.sv
// ----------------------------------------------------------------------------
// hdd_in_if
// Delta item channel: valid, ready and one grid delta with its base offset.
// ----------------------------------------------------------------------------
interface hdd_in_if
  import hdd_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      grid_start;
  logic signed [BASE_W-1:0]  base_offset;
  logic signed [DELTA_W-1:0] height_delta;

  modport source (output valid, grid_start, base_offset, height_delta, input ready);
  modport sink   (input valid, grid_start, base_offset, height_delta, output ready);
endinterface

### rtl/hdd_out_if.sv
// ----------------------------------------------------------------------------
// hdd_out_if
// Result item channel: height samples and per-quadrant minimum and maximum.
// ----------------------------------------------------------------------------
interface hdd_out_if
  import hdd_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic                       result_kind;
  logic [QUAD_W-1:0]          quadrant;
  logic [INDEX_W-1:0]         local_index;
  logic signed [HEIGHT_W-1:0] height_value;
  logic signed [HEIGHT_W-1:0] quad_min;
  logic signed [HEIGHT_W-1:0] quad_max;
  logic                       last_result;

  modport source (output valid, result_kind, quadrant, local_index, height_value,
                  quad_min, quad_max, last_result, input ready);
  modport sink   (input valid, result_kind, quadrant, local_index, height_value,
                  quad_min, quad_max, last_result, output ready);
endinterface

### rtl/heightmap_delta_decode.sv
// ----------------------------------------------------------------------------
// heightmap_delta_decode
// Rebuilds a square height grid from row-major deltas and fans each height
// out to the quadrants that hold it, then reports quadrant minima and maxima.
// ----------------------------------------------------------------------------
// din carries one delta item per handshake; grid_start marks the first delta
// of a grid and loads base_offset. dout carries result items: one height
// sample per quadrant that holds the vertex (ascending quadrant order), and
// after the final vertex of a grid four min/max items, quadrants 0 to 3.
// last_result marks the final result of each input item.
// An accepted item is held in the input register, is decoded into the burst
// register, and its results are sent one by one from the result register.
// Throughput: one item per cycle while items give one result each and dout
// does not stall. The output port moves one result per cycle, so a vertex on
// the shared middle row or column gives two results, the center vertex four,
// and the final vertex four min/max items more.
// Reset clears the accumulators, the position counters and the min/max
// registers. When dout stalls the result register holds, the burst register
// fills behind it, then the input register, and din.ready drops.
// ----------------------------------------------------------------------------
module heightmap_delta_decode
  import hdd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  hdd_in_if.sink          din,
  hdd_out_if.source       dout
);

  // input register
  logic                      in_valid_q;
  logic                      in_start_q;
  logic signed [BASE_W-1:0]  in_base_q;
  logic signed [DELTA_W-1:0] in_delta_q;

  // decoder state
  logic signed [ACC_W-1:0]    row_acc;
  logic signed [ACC_W-1:0]    run_acc;
  logic [CNT_W-1:0]           row_cnt;
  logic [CNT_W-1:0]           col_cnt;
  logic signed [HEIGHT_W-1:0] quad_lo [NUM_QUADS];
  logic signed [HEIGHT_W-1:0] quad_hi [NUM_QUADS];

  // burst register: results of one item still to be sent
  logic [NUM_QUADS-1:0]       mask_q;
  logic                       final_q;
  logic [QUAD_W-1:0]          mm_cnt;
  logic signed [HEIGHT_W-1:0] h_q;
  logic [INDEX_W-1:0]         idx_q   [NUM_QUADS];
  logic signed [HEIGHT_W-1:0] snap_lo [NUM_QUADS];
  logic signed [HEIGHT_W-1:0] snap_hi [NUM_QUADS];

  // result register
  logic                       out_valid_q;
  logic                       out_kind_q;
  logic [QUAD_W-1:0]          out_quad_q;
  logic [INDEX_W-1:0]         out_idx_q;
  logic signed [HEIGHT_W-1:0] out_h_q;
  logic signed [HEIGHT_W-1:0] out_lo_q;
  logic signed [HEIGHT_W-1:0] out_hi_q;
  logic                       out_last_q;

  // decode logic
  logic signed [ACC_W-1:0]    row_base;
  logic signed [ACC_W-1:0]    delta_ext;
  logic signed [ACC_W-1:0]    row_acc_next;
  logic signed [ACC_W-1:0]    run_acc_next;
  logic [CNT_W-1:0]           r_cur;
  logic [CNT_W-1:0]           c_cur;
  logic [CNT_W-1:0]           row_cnt_next;
  logic [CNT_W-1:0]           col_cnt_next;
  logic                       final_new;
  logic signed [HEIGHT_W-1:0] h_new;
  logic [NUM_QUADS-1:0]       mask_new;
  logic [INDEX_W-1:0]         idx_new [NUM_QUADS];
  logic signed [HEIGHT_W-1:0] lo_upd  [NUM_QUADS];
  logic signed [HEIGHT_W-1:0] hi_upd  [NUM_QUADS];

  // burst sequencing
  logic                       busy;
  logic                       emit;
  logic                       emit_last;
  logic                       finishing;
  logic                       burst_load;
  logic [QUAD_W-1:0]          sel;
  logic [NUM_QUADS-1:0]       mask_rest;
  logic                       e_kind;
  logic [QUAD_W-1:0]          e_quad;
  logic [INDEX_W-1:0]         e_idx;
  logic signed [HEIGHT_W-1:0] e_h;
  logic signed [HEIGHT_W-1:0] e_lo;
  logic signed [HEIGHT_W-1:0] e_hi;

  always_comb begin
    logic in_row;
    logic in_col;
    logic [CNT_W-1:0] lr;
    logic [CNT_W-1:0] lc;
    logic [PROD_W-1:0] prod;
    logic signed [HEIGHT_W-1:0] lo_cur;
    logic signed [HEIGHT_W-1:0] hi_cur;

    row_base  = in_start_q ? {{(ACC_W-BASE_W){in_base_q[BASE_W-1]}}, in_base_q} : row_acc;
    delta_ext = {{(ACC_W-DELTA_W-FRAC_W){in_delta_q[DELTA_W-1]}}, in_delta_q,
                 {FRAC_W{1'b0}}};
    r_cur = in_start_q ? '0 : row_cnt;
    c_cur = in_start_q ? '0 : col_cnt;

    if (c_cur == '0) begin
      row_acc_next = row_base + delta_ext;
      run_acc_next = row_acc_next;
    end else begin
      row_acc_next = row_base;
      run_acc_next = run_acc + delta_ext;
    end
    // the height is the accumulator times 8: three zero bits appended below
    h_new = {run_acc_next, {SCALE_W{1'b0}}};

    final_new = 1'b0;
    if (c_cur == CNT_W'(GRID_PITCH - 1)) begin
      col_cnt_next = '0;
      if (r_cur == CNT_W'(GRID_PITCH - 1)) begin
        row_cnt_next = '0;
        final_new    = 1'b1;
      end else begin
        row_cnt_next = r_cur + 1'b1;
      end
    end else begin
      col_cnt_next = c_cur + 1'b1;
      row_cnt_next = r_cur;
    end

    for (int q = 0; q < NUM_QUADS; q++) begin
      // quadrant row is bit 1, quadrant column bit 0; middle row/column shared
      in_row = (q / 2 == 1) ? (r_cur >= CNT_W'(HALF_PITCH)) : (r_cur <= CNT_W'(HALF_PITCH));
      in_col = (q % 2 == 1) ? (c_cur >= CNT_W'(HALF_PITCH)) : (c_cur <= CNT_W'(HALF_PITCH));
      lr = (q / 2 == 1) ? r_cur - CNT_W'(HALF_PITCH) : r_cur;
      lc = (q % 2 == 1) ? c_cur - CNT_W'(HALF_PITCH) : c_cur;
      prod = PROD_W'(lr) * PROD_W'(QUAD_PITCH) + PROD_W'(lc);
      mask_new[q] = in_row && in_col;
      idx_new[q]  = prod[INDEX_W-1:0];

      lo_cur = in_start_q ? HEIGHT_MOST_POS : quad_lo[q];
      hi_cur = in_start_q ? HEIGHT_MOST_NEG : quad_hi[q];
      lo_upd[q] = (mask_new[q] && (h_new < lo_cur)) ? h_new : lo_cur;
      hi_upd[q] = (mask_new[q] && (h_new > hi_cur)) ? h_new : hi_cur;
    end
  end

  always_comb begin
    sel = '0;
    for (int q = NUM_QUADS - 1; q >= 0; q--) begin
      if (mask_q[q]) begin
        sel = QUAD_W'(q);
      end
    end
    mask_rest = mask_q & ~(NUM_QUADS'(1) << sel);

    busy = (|mask_q) || final_q;
    emit = busy && (!out_valid_q || dout.ready);

    if (|mask_q) begin
      e_kind    = KIND_SAMPLE;
      e_quad    = sel;
      e_idx     = idx_q[sel];
      e_h       = h_q;
      e_lo      = '0;
      e_hi      = '0;
      emit_last = (mask_rest == '0) && !final_q;
    end else begin
      e_kind    = KIND_MINMAX;
      e_quad    = mm_cnt;
      e_idx     = '0;
      e_h       = '0;
      e_lo      = snap_lo[mm_cnt];
      e_hi      = snap_hi[mm_cnt];
      emit_last = (mm_cnt == QUAD_W'(NUM_QUADS - 1));
    end

    finishing  = emit && emit_last;
    burst_load = in_valid_q && (!busy || finishing);
  end

  assign din.ready = !in_valid_q || burst_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (din.valid && din.ready) begin
      in_valid_q <= 1'b1;
    end else if (burst_load) begin
      in_valid_q <= 1'b0;
    end
    if (din.valid && din.ready) begin
      in_start_q <= din.grid_start;
      in_base_q  <= din.base_offset;
      in_delta_q <= din.height_delta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_acc <= '0;
      run_acc <= '0;
      row_cnt <= '0;
      col_cnt <= '0;
      for (int q = 0; q < NUM_QUADS; q++) begin
        quad_lo[q] <= HEIGHT_MOST_POS;
        quad_hi[q] <= HEIGHT_MOST_NEG;
      end
    end else if (burst_load) begin
      row_acc <= row_acc_next;
      run_acc <= run_acc_next;
      row_cnt <= row_cnt_next;
      col_cnt <= col_cnt_next;
      for (int q = 0; q < NUM_QUADS; q++) begin
        quad_lo[q] <= final_new ? HEIGHT_MOST_POS : lo_upd[q];
        quad_hi[q] <= final_new ? HEIGHT_MOST_NEG : hi_upd[q];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_q  <= '0;
      final_q <= 1'b0;
      mm_cnt  <= '0;
    end else if (burst_load) begin
      mask_q  <= mask_new;
      final_q <= final_new;
      mm_cnt  <= '0;
    end else if (emit) begin
      if (|mask_q) begin
        mask_q <= mask_rest;
      end else begin
        mm_cnt <= mm_cnt + 1'b1;
        if (emit_last) begin
          final_q <= 1'b0;
        end
      end
    end
    if (burst_load) begin
      h_q <= h_new;
      for (int q = 0; q < NUM_QUADS; q++) begin
        idx_q[q]   <= idx_new[q];
        snap_lo[q] <= lo_upd[q];
        snap_hi[q] <= hi_upd[q];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (dout.ready) begin
      out_valid_q <= 1'b0;
    end
    if (emit) begin
      out_kind_q <= e_kind;
      out_quad_q <= e_quad;
      out_idx_q  <= e_idx;
      out_h_q    <= e_h;
      out_lo_q   <= e_lo;
      out_hi_q   <= e_hi;
      out_last_q <= emit_last;
    end
  end

  assign dout.valid        = out_valid_q;
  assign dout.result_kind  = out_kind_q;
  assign dout.quadrant     = out_quad_q;
  assign dout.local_index  = out_idx_q;
  assign dout.height_value = out_h_q;
  assign dout.quad_min     = out_lo_q;
  assign dout.quad_max     = out_hi_q;
  assign dout.last_result  = out_last_q;

`ifndef SYNTH
  // every vertex lies in at least one quadrant, so a loaded burst is never empty
  a_burst_nonempty: assert property (@(posedge clk) disable iff (rst)
    burst_load |=> busy)
    else $error("loaded burst has no results");

  // decoder state moves only when an item enters the burst register
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !burst_load |=> $stable(row_acc) && $stable(run_acc) && $stable(col_cnt))
    else $error("decoder state changed without an item");

  // min/max items go out only after all height samples of the burst
  a_minmax_after_samples: assert property (@(posedge clk) disable iff (rst)
    (emit && e_kind == KIND_MINMAX) |-> (mask_q == '0) && final_q)
    else $error("min/max item sent ahead of samples");
`endif

endmodule
